// ----- src/uwm_pkg.sv -----
// uwm_pkg: shared constants and types of the text width measure block
// used by uwm_ctrl, uwm_dp and the top level in src, no dependencies
package uwm_pkg;

	localparam int MAX_GLYPHS_DEF = 256;

	localparam int EM_W      = 12;
	localparam int PIX_W     = 10;
	localparam int GCNT_W    = 9;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CODE_W    = 21;
	localparam int ADV_W     = 20;
	localparam int SUM_W     = 32;
	localparam int PROD_W    = SUM_W + PIX_W;
	localparam int ENTRY_W   = ADV_W + 1 + CODE_W;
	localparam int DCNT_W    = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EM_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 2'd2;

	localparam logic [EM_W-1:0]   EM_RESET   = 12'd1000;
	localparam logic [PIX_W-1:0]  PIX_RESET  = 10'd16;
	localparam logic [GCNT_W-1:0] GCNT_RESET = 9'd0;

	// func codes
	localparam logic [1:0] F_LOAD = 2'd0;
	localparam logic [1:0] F_BYTE = 2'd1;
	localparam logic [1:0] F_END  = 2'd2;

	// utf-8 lead byte classes
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] LEAD4_BITS = 8'h07;
	localparam logic [7:0] CONT_BITS  = 8'h3F;
	localparam logic [CODE_W-1:0] CP_QMARK = 21'h3F;

	// default advance 0.6 em in q12.8: (em * 1536 + 5) / 10
	localparam int DFLT_X_W = 23;
	localparam logic [10:0] DFLT_MUL = 11'd1536;
	localparam logic [2:0]  DFLT_RND = 3'd5;
	localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
	localparam int DIV10_SHIFT = 35;

	typedef struct packed {
		logic wr_glyph;
		logic dec_byte;
		logic end_cp;
		logic srch;
		logic mul;
		logic div;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic byte_done;
		logic pending_nz;
		logic srch_done;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ----- src/uwm_ram.sv -----
// uwm_ram: generic simple dual port ram with registered read
// no dependencies
module uwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/uwm_ctrl.sv -----
// uwm_ctrl: sequencing state machine of the text width measure block
// depends on uwm_pkg
module uwm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          func,
	input  uwm_pkg::status_t    status,
	output logic                in_stall,
	output uwm_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       end_q, end_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		end_d   = end_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						uwm_pkg::F_LOAD: cmd.wr_glyph = 1'b1;
						uwm_pkg::F_BYTE: begin
							cmd.dec_byte = 1'b1;
							if (status.byte_done) state_d = ST_SRCH;
						end
						uwm_pkg::F_END: begin
							cmd.end_cp = 1'b1;
							end_d      = 1'b1;
							state_d    = status.pending_nz ? ST_SRCH : ST_MUL;
						end
						default: ;
					endcase
				end
			end
			ST_SRCH: begin
				cmd.srch = 1'b1;
				if (status.srch_done) state_d = end_q ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (status.div_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					end_d    = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
		end
	end

endmodule

// ----- src/uwm_dp.sv -----
// uwm_dp: datapath with utf-8 decoder, glyph search, sum, multiply and divider
// depends on uwm_pkg and uwm_ram
module uwm_dp #(
	parameter int MAX_GLYPHS = uwm_pkg::MAX_GLYPHS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uwm_pkg::cmd_t                 cmd,
	output uwm_pkg::status_t              status,
	input  logic                          cfg_wen,
	input  logic [uwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uwm_pkg::CFG_W-1:0]     cfg_data,
	input  logic [7:0]                    glyph_index,
	input  logic [uwm_pkg::CODE_W-1:0]    glyph_code,
	input  logic                          glyph_valid,
	input  logic [uwm_pkg::ADV_W-1:0]     glyph_advance,
	input  logic [7:0]                    text_byte,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [uwm_pkg::SUM_W-1:0]     text_width,
	output logic                          width_saturated
);

	localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int CW = $clog2(MAX_GLYPHS + 1);
	localparam int LW = (CW > 13) ? CW : 13;
	localparam int CODE_W = uwm_pkg::CODE_W;
	localparam int ADV_W  = uwm_pkg::ADV_W;
	localparam int SUM_W  = uwm_pkg::SUM_W;
	localparam int PROD_W = uwm_pkg::PROD_W;
	localparam int EM_W   = uwm_pkg::EM_W;
	localparam int XW     = uwm_pkg::DFLT_X_W;
	localparam int MW     = XW + 32;

	// configuration
	logic [EM_W-1:0]           em_q;
	logic [uwm_pkg::PIX_W-1:0] pix_q;
	logic [uwm_pkg::GCNT_W-1:0] gcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_q   <= uwm_pkg::EM_RESET;
			pix_q  <= uwm_pkg::PIX_RESET;
			gcnt_q <= uwm_pkg::GCNT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				uwm_pkg::CFG_EM_SIZE:     em_q   <= cfg_data[EM_W-1:0];
				uwm_pkg::CFG_PIXEL_SIZE:  pix_q  <= cfg_data[uwm_pkg::PIX_W-1:0];
				uwm_pkg::CFG_GLYPH_COUNT: gcnt_q <= cfg_data[uwm_pkg::GCNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [EM_W-1:0] em_eff;
	assign em_eff = (em_q == '0) ? EM_W'(1) : em_q;

	// default advance by reciprocal multiply, registered
	logic [XW-1:0]    dflt_x;
	logic [MW-1:0]    dflt_p;
	logic [ADV_W-1:0] dflt_q;
	assign dflt_x = XW'(em_eff) * XW'(uwm_pkg::DFLT_MUL) + XW'(uwm_pkg::DFLT_RND);
	assign dflt_p = MW'(dflt_x) * MW'(uwm_pkg::DIV10_RECIP);
	always_ff @(posedge clk) begin
		dflt_q <= ADV_W'(dflt_p >> uwm_pkg::DIV10_SHIFT);
	end

	// search limit
	logic [LW-1:0] gc_ext, lim_ext;
	logic [CW-1:0] limit;
	assign gc_ext  = LW'(gcnt_q);
	assign lim_ext = (gc_ext > LW'(MAX_GLYPHS)) ? LW'(MAX_GLYPHS) : gc_ext;
	assign limit   = CW'(lim_ext);

	// glyph table
	logic                           wr_ok;
	logic [uwm_pkg::ENTRY_W-1:0]    rdata;
	logic [CW-1:0]                  cnt_q;
	logic                           cmp_vld_q;
	assign wr_ok = LW'(glyph_index) < LW'(MAX_GLYPHS);

	uwm_ram #(
		.WIDTH(uwm_pkg::ENTRY_W),
		.DEPTH(MAX_GLYPHS)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_glyph && wr_ok),
		.waddr(AW'(glyph_index)),
		.wdata({glyph_advance, glyph_valid, glyph_code}),
		.raddr(cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	logic [CODE_W-1:0] ent_code;
	logic              ent_valid;
	logic [ADV_W-1:0]  ent_adv;
	assign ent_code  = rdata[CODE_W-1:0];
	assign ent_valid = rdata[CODE_W];
	assign ent_adv   = rdata[uwm_pkg::ENTRY_W-1:CODE_W+1];

	// utf-8 decoder
	logic [CODE_W-1:0] partial_q, cp_q;
	logic [1:0]        pend_q;
	logic [CODE_W-1:0] nxt_partial, dec_cp, cont;
	logic [1:0]        nxt_pend, np;
	logic              byte_done;

	always_comb begin
		nxt_partial = partial_q;
		nxt_pend    = pend_q;
		dec_cp      = '0;
		byte_done   = 1'b0;
		np          = pend_q - 2'd1;
		cont        = CODE_W'(text_byte & uwm_pkg::CONT_BITS);
		if (pend_q != 2'd0) begin
			case (np)
				2'd0:    cont = cont;
				2'd1:    cont = cont << 6;
				default: cont = cont << 12;
			endcase
			nxt_pend = np;
			if (np == 2'd0) begin
				byte_done   = 1'b1;
				dec_cp      = partial_q | cont;
				nxt_partial = '0;
			end else begin
				nxt_partial = partial_q | cont;
			end
		end else if ((text_byte & uwm_pkg::ASCII_MASK) == 8'h00) begin
			byte_done = 1'b1;
			dec_cp    = CODE_W'(text_byte);
		end else if ((text_byte & uwm_pkg::LEAD2_MASK) == uwm_pkg::LEAD2_CODE) begin
			nxt_partial = CODE_W'(text_byte & uwm_pkg::LEAD2_BITS) << 6;
			nxt_pend    = 2'd1;
		end else if ((text_byte & uwm_pkg::LEAD3_MASK) == uwm_pkg::LEAD3_CODE) begin
			nxt_partial = CODE_W'(text_byte & uwm_pkg::LEAD3_BITS) << 12;
			nxt_pend    = 2'd2;
		end else if ((text_byte & uwm_pkg::LEAD4_MASK) == uwm_pkg::LEAD4_CODE) begin
			nxt_partial = CODE_W'(text_byte & uwm_pkg::LEAD4_BITS) << 18;
			nxt_pend    = 2'd3;
		end else begin
			byte_done = 1'b1;
			dec_cp    = uwm_pkg::CP_QMARK;
		end
	end

	// search compare and sum
	logic              hit, issue, srch_done;
	logic [ADV_W-1:0]  adv;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_q;
	logic              clip_q;

	assign hit       = cmp_vld_q && (ent_code == cp_q);
	assign issue     = cnt_q < limit;
	assign srch_done = (limit == '0) || hit || (cmp_vld_q && (cnt_q == limit));
	assign adv       = (hit && ent_valid) ? ent_adv : dflt_q;
	assign sum_ext   = (SUM_W+1)'(sum_q) + (SUM_W+1)'(adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= '0;
			sum_q     <= '0;
			clip_q    <= 1'b0;
			cnt_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			if (cmd.dec_byte) begin
				partial_q <= nxt_partial;
				pend_q    <= nxt_pend;
			end
			if (cmd.dec_byte || cmd.end_cp) begin
				cnt_q     <= '0;
				cmp_vld_q <= 1'b0;
			end else if (cmd.srch) begin
				if (issue) cnt_q <= cnt_q + CW'(1);
				cmp_vld_q <= issue;
			end
			if (cmd.srch && srch_done) begin
				if (sum_ext[SUM_W]) begin
					sum_q  <= '1;
					clip_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
			end
			if (cmd.emit) begin
				partial_q <= '0;
				pend_q    <= '0;
				sum_q     <= '0;
				clip_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dec_byte) cp_q <= dec_cp;
		else if (cmd.end_cp) cp_q <= partial_q;
	end

	// scaling: multiply, then restoring divide one bit per cycle
	logic [PROD_W-1:0]       q_q;
	logic [EM_W-1:0]         r_q;
	logic [uwm_pkg::DCNT_W-1:0] dcnt_q;
	logic [EM_W:0]           trial;
	logic                    ge;

	assign trial = {r_q, q_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, em_eff};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			q_q    <= PROD_W'(sum_q) * PROD_W'(pix_q);
			r_q    <= '0;
			dcnt_q <= '0;
		end else if (cmd.div) begin
			r_q    <= ge ? EM_W'(trial - {1'b0, em_eff}) : trial[EM_W-1:0];
			q_q    <= {q_q[PROD_W-2:0], ge};
			dcnt_q <= dcnt_q + uwm_pkg::DCNT_W'(1);
		end
	end

	// output register
	logic              out_valid_q, sat;
	logic [SUM_W-1:0]  width_q;
	logic              flag_q;
	assign sat = |q_q[PROD_W-1:SUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			width_q <= sat ? '1 : q_q[SUM_W-1:0];
			flag_q  <= sat || clip_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign text_width      = width_q;
	assign width_saturated = flag_q;

	assign status.byte_done  = byte_done;
	assign status.pending_nz = (pend_q != 2'd0);
	assign status.srch_done  = srch_done;
	assign status.div_last   = (dcnt_q == uwm_pkg::DCNT_W'(PROD_W - 1));
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule

// ----- src/utf8_text_width_measure_unit.sv -----
// utf8_text_width_measure_unit: top level of the utf-8 text width measure block
// depends on uwm_pkg, uwm_ctrl, uwm_dp and uwm_ram
//
// loads glyph entries (func 0) into a table ram, decodes a utf-8 byte stream
// (func 1), sums the advance of each decoded codepoint and on end of text
// (func 2) returns floor(sum * pixel_size / em_size) with a saturation flag.
// one transaction is taken at a time: a glyph load or a byte that does not
// finish a codepoint is done in idle; a byte that finishes a codepoint runs a
// search that compares entries up to and including the first match (at most
// min(glyph count, MAX_GLYPHS)) through the single table read port doing
// one compare per cycle; end of text runs a search for a cut-short sequence
// if one is pending, then a multiply and the 42-step bit-serial divider.
// the result sits in an output register; a new transaction is taken while
// it waits, a following end of text waits until it is taken.
module utf8_text_width_measure_unit #(
	parameter int MAX_GLYPHS = uwm_pkg::MAX_GLYPHS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wen,
	input  logic [uwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uwm_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [7:0]                    glyph_index,
	input  logic [uwm_pkg::CODE_W-1:0]    glyph_code,
	input  logic                          glyph_valid,
	input  logic [uwm_pkg::ADV_W-1:0]     glyph_advance,
	input  logic [7:0]                    text_byte,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [uwm_pkg::SUM_W-1:0]     text_width,
	output logic                          width_saturated
);

	uwm_pkg::cmd_t    cmd;
	uwm_pkg::status_t status;

	// sequencer
	uwm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.status  (status),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	// decoder, search, accumulate and scale
	uwm_dp #(
		.MAX_GLYPHS(MAX_GLYPHS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.glyph_index    (glyph_index),
		.glyph_code     (glyph_code),
		.glyph_valid    (glyph_valid),
		.glyph_advance  (glyph_advance),
		.text_byte      (text_byte),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.text_width     (text_width),
		.width_saturated(width_saturated)
	);

endmodule

// ----- tb/tb_utf8_text_width_measure_unit.sv -----
// tb_utf8_text_width_measure_unit: self-checking testbench of the utf-8 text width measure block
// depends on uwm_pkg and utf8_text_width_measure_unit, predicts every result from its own model
module tb_utf8_text_width_measure_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CODE_W         = uwm_pkg::CODE_W;
	localparam int ADV_W          = uwm_pkg::ADV_W;
	localparam int SUM_W          = uwm_pkg::SUM_W;
	localparam int CFG_IDX_W      = uwm_pkg::CFG_IDX_W;
	localparam int CFG_W          = uwm_pkg::CFG_W;
	localparam int MAX_GLYPHS_DEF = uwm_pkg::MAX_GLYPHS_DEF;
	localparam int EM_W           = uwm_pkg::EM_W;
	localparam int PIX_W          = uwm_pkg::PIX_W;
	localparam int GCNT_W         = uwm_pkg::GCNT_W;
	localparam logic [EM_W-1:0]   EM_RESET   = uwm_pkg::EM_RESET;
	localparam logic [PIX_W-1:0]  PIX_RESET  = uwm_pkg::PIX_RESET;
	localparam logic [GCNT_W-1:0] GCNT_RESET = uwm_pkg::GCNT_RESET;
	localparam logic [1:0] F_LOAD = uwm_pkg::F_LOAD;
	localparam logic [1:0] F_BYTE = uwm_pkg::F_BYTE;
	localparam logic [1:0] F_END  = uwm_pkg::F_END;
	localparam logic [7:0] ASCII_MASK = uwm_pkg::ASCII_MASK;
	localparam logic [7:0] LEAD2_MASK = uwm_pkg::LEAD2_MASK;
	localparam logic [7:0] LEAD2_CODE = uwm_pkg::LEAD2_CODE;
	localparam logic [7:0] LEAD2_BITS = uwm_pkg::LEAD2_BITS;
	localparam logic [7:0] LEAD3_MASK = uwm_pkg::LEAD3_MASK;
	localparam logic [7:0] LEAD3_CODE = uwm_pkg::LEAD3_CODE;
	localparam logic [7:0] LEAD3_BITS = uwm_pkg::LEAD3_BITS;
	localparam logic [7:0] LEAD4_MASK = uwm_pkg::LEAD4_MASK;
	localparam logic [7:0] LEAD4_CODE = uwm_pkg::LEAD4_CODE;
	localparam logic [7:0] LEAD4_BITS = uwm_pkg::LEAD4_BITS;
	localparam logic [7:0] CONT_BITS  = uwm_pkg::CONT_BITS;
	localparam logic [CODE_W-1:0] CP_QMARK = uwm_pkg::CP_QMARK;
	localparam logic [CFG_IDX_W-1:0] CFG_EM_SIZE     = uwm_pkg::CFG_EM_SIZE;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE  = uwm_pkg::CFG_PIXEL_SIZE;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = uwm_pkg::CFG_GLYPH_COUNT;

	// func 3 is unused: the block must drop it silently
	localparam logic [1:0] F_NONE = 2'd3;
	localparam int RUN_LIMIT = 1200000;
	localparam int SETTLE_CYCLES = 600;
	localparam int RANDOM_ITEMS = 560;

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        slot;
		logic [CODE_W-1:0] code;
		logic              defined;
		logic [ADV_W-1:0]  adv;
		logic [7:0]        data;
	} txn_t;

	typedef struct packed {
		logic [SUM_W-1:0] width;
		logic             sat;
	} width_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [SUM_W-1:0] text_width;
	logic width_saturated;
	txn_t cur = '0;

	// queue of transactions waiting for the driver, and widths still owed by the block
	txn_t pending_txns[$];
	width_t widths_due[$];

	// shadow of the glyph table, configuration and running text state
	logic [CODE_W-1:0] tbl_code [MAX_GLYPHS_DEF];
	logic              tbl_def  [MAX_GLYPHS_DEF];
	logic [ADV_W-1:0]  tbl_adv  [MAX_GLYPHS_DEF];
	logic [EM_W-1:0]   em_reg = EM_RESET;
	logic [PIX_W-1:0]  pix_reg = PIX_RESET;
	logic [GCNT_W-1:0] gcnt_reg = GCNT_RESET;
	logic [SUM_W-1:0]  run_sum = '0;
	logic [CODE_W-1:0] seq_code = '0;
	int unsigned       seq_left = 0;
	logic              run_clipped = 1'b0;

	int errors = 0;
	int cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit calm = 1'b0;
	int random_pushed = 0;

	utf8_text_width_measure_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(cur.op), .glyph_index(cur.slot), .glyph_code(cur.code),
		.glyph_valid(cur.defined), .glyph_advance(cur.adv), .text_byte(cur.data),
		.out_valid(out_valid), .out_stall(out_stall),
		.text_width(text_width), .width_saturated(width_saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle counter, timeout, and the switch between calm stretches and bursty idling
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 256 == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
		end
		if (cycles >= RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		$display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
	endtask

	// effective em for the 0.6 em q12.8 default advance and the scaling; em 0 behaves as 1
	function automatic logic [63:0] eff_em();
		return (em_reg == 0) ? 64'd1 : 64'(em_reg);
	endfunction

	// first match among the searched entries wins, else the default advance
	function automatic void add_glyph(logic [CODE_W-1:0] cp);
		int limit;
		logic [63:0] adv;
		logic [32:0] s;
		limit = (gcnt_reg > MAX_GLYPHS_DEF) ? MAX_GLYPHS_DEF : int'(gcnt_reg);
		adv = (eff_em() * 1536 + 5) / 10;
		for (int i = 0; i < limit; i++) begin
			if (tbl_code[i] == cp) begin
				if (tbl_def[i])
					adv = 64'(tbl_adv[i]);
				break;
			end
		end
		s = 33'(run_sum) + 33'(adv);
		if (s[32]) begin
			run_sum = '1;
			run_clipped = 1'b1;
		end else begin
			run_sum = s[31:0];
		end
	endfunction

	// one accepted transaction: update the shadow state, queue the width it owes
	function automatic void measure_txn(txn_t t);
		logic [63:0] scaled;
		width_t w;
		case (t.op)
			F_LOAD: begin
				tbl_code[t.slot] = t.code;
				tbl_def[t.slot] = t.defined;
				tbl_adv[t.slot] = t.adv;
			end
			F_BYTE: begin
				if (seq_left != 0) begin
					seq_left--;
					seq_code = seq_code | (CODE_W'(t.data & CONT_BITS) << (6 * seq_left));
					if (seq_left == 0) begin
						add_glyph(seq_code);
						seq_code = '0;
					end
				end else if ((t.data & ASCII_MASK) == 0) begin
					add_glyph(CODE_W'(t.data));
				end else if ((t.data & LEAD2_MASK) == LEAD2_CODE) begin
					seq_code = CODE_W'(t.data & LEAD2_BITS) << 6;
					seq_left = 1;
				end else if ((t.data & LEAD3_MASK) == LEAD3_CODE) begin
					seq_code = CODE_W'(t.data & LEAD3_BITS) << 12;
					seq_left = 2;
				end else if ((t.data & LEAD4_MASK) == LEAD4_CODE) begin
					seq_code = CODE_W'(t.data & LEAD4_BITS) << 18;
					seq_left = 3;
				end else begin
					add_glyph(CP_QMARK);
				end
			end
			F_END: begin
				// a cut-short sequence is measured with its missing bits at zero
				if (seq_left != 0)
					add_glyph(seq_code);
				scaled = (64'(run_sum) * 64'(pix_reg)) / eff_em();
				w.sat = run_clipped;
				if (scaled > 64'hFFFF_FFFF) begin
					scaled = 64'hFFFF_FFFF;
					w.sat = 1'b1;
				end
				w.width = scaled[31:0];
				widths_due.push_back(w);
				run_sum = '0;
				seq_code = '0;
				seq_left = 0;
				run_clipped = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// driver: holds a stalled transaction, otherwise idles or moves on to the next one
	always @(posedge clk) begin
		txn_t t;
		if (arst_n) begin
			if (in_valid && !in_stall)
				measure_txn(cur);
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_txns.size() > 0) begin
				t = pending_txns.pop_front();
				cur <= t;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure, each taken width checked against the oldest one due
	always @(posedge clk) begin
		width_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (widths_due.size() == 0) begin
					report("unexpected width", 64'd0, 64'(text_width));
				end else begin
					w = widths_due.pop_front();
					if (text_width !== w.width)
						report("text_width", 64'(w.width), 64'(text_width));
					if (width_saturated !== w.sat)
						report("width_saturated", 64'(w.sat), 64'(width_saturated));
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_gap <= pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void push_load(int slot, logic [CODE_W-1:0] code, bit defd,
			logic [ADV_W-1:0] adv);
		txn_t t;
		t = '0;
		t.op = F_LOAD;
		t.slot = 8'(slot);
		t.code = code;
		t.defined = defd;
		t.adv = adv;
		pending_txns.push_back(t);
	endfunction

	function automatic void push_byte(logic [7:0] b);
		txn_t t;
		// unused fields carry noise so that the block must ignore them
		t.op = F_BYTE;
		t.slot = 8'($urandom);
		t.code = CODE_W'($urandom);
		t.defined = 1'($urandom);
		t.adv = ADV_W'($urandom);
		t.data = b;
		pending_txns.push_back(t);
	endfunction

	function automatic void push_op(logic [1:0] op);
		txn_t t;
		t = txn_t'({$urandom, $urandom, $urandom});
		t.op = op;
		pending_txns.push_back(t);
	endfunction

	// codepoint from one of the four encoded lengths
	function automatic logic [CODE_W-1:0] rand_code();
		case ($urandom_range(0, 3))
			0: return CODE_W'($urandom_range(0, 'h7F));
			1: return CODE_W'($urandom_range('h80, 'h7FF));
			2: return CODE_W'($urandom_range('h800, 'hFFFF));
			default: return CODE_W'($urandom_range('h10000, 'h1FFFFF));
		endcase
	endfunction

	// encode a codepoint; cut > 0 drops that many trailing bytes, keeping at least the lead byte
	function automatic int push_utf8(logic [CODE_W-1:0] cp, int cut);
		int n;
		logic [7:0] b [4];
		if (cp < 'h80) begin
			n = 1;
			b[0] = 8'(cp);
		end else if (cp < 'h800) begin
			n = 2;
			b[0] = 8'hC0 | 8'(cp >> 6);
		end else if (cp < 'h10000) begin
			n = 3;
			b[0] = 8'hE0 | 8'(cp >> 12);
		end else begin
			n = 4;
			b[0] = 8'hF0 | 8'(cp >> 18);
		end
		for (int i = 1; i < n; i++)
			b[i] = 8'h80 | 8'((cp >> (6 * (n - 1 - i))) & 'h3F);
		if (cut >= n)
			cut = n - 1;
		for (int i = 0; i < n - cut; i++)
			push_byte(b[i]);
		return n - cut;
	endfunction

	// a text of mostly well-formed glyphs known to the table, some noise, some cut short
	task automatic push_text(int glyphs);
		int searched;
		int r;
		logic [CODE_W-1:0] cp;
		searched = (gcnt_reg > MAX_GLYPHS_DEF) ? MAX_GLYPHS_DEF : int'(gcnt_reg);
		for (int g = 0; g < glyphs; g++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_byte(8'($urandom));
				random_pushed++;
			end else begin
				if (r < 70 && searched > 0)
					cp = tbl_code[$urandom_range(0, searched - 1)];
				else
					cp = rand_code();
				random_pushed += push_utf8(cp, 0);
			end
		end
		if ($urandom_range(0, 5) == 0)
			random_pushed += push_utf8(rand_code() | 21'h800, $urandom_range(1, 3));
		if ($urandom_range(0, 19) == 0) begin
			push_op(F_NONE);
			random_pushed++;
		end
		push_op(F_END);
		random_pushed++;
	endtask

	// wait for the block to drain, including a search still running after the last width
	task automatic settle();
		while (pending_txns.size() > 0 || in_valid || widths_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_EM_SIZE: em_reg = EM_W'(value);
			CFG_PIXEL_SIZE: pix_reg = PIX_W'(value);
			CFG_GLYPH_COUNT: gcnt_reg = GCNT_W'(value);
			default: ;
		endcase
	endtask

	task automatic set_font(int unsigned em, int unsigned pix, int unsigned cnt);
		settle();
		cfg_write(CFG_EM_SIZE, em);
		cfg_write(CFG_PIXEL_SIZE, pix);
		cfg_write(CFG_GLYPH_COUNT, cnt);
	endtask

	initial begin
		int unsigned em;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, empty search: ascii extremes, lead classes, bad leads
		push_byte(8'h00);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'hF8);
		void'(push_utf8(21'h0E9, 0));
		void'(push_utf8(21'h20AC, 0));
		void'(push_utf8(21'h1F600, 0));
		push_op(F_END);
		// cut-short sequence, unused func, empty text
		push_byte(8'hE2);
		push_op(F_END);
		push_op(F_NONE);
		push_op(F_END);

		// fill the whole table so no search ever reaches an unwritten entry
		push_load(0, '0, 1'b1, '0);
		for (int i = 1; i < MAX_GLYPHS_DEF - 1; i++)
			push_load(i, rand_code(), ($urandom_range(0, 4) != 0), ADV_W'($urandom));
		push_load(MAX_GLYPHS_DEF - 1, '1, 1'b1, '1);

		// product overflow on a short text with the widest advance
		set_font(1, 1023, 1);
		push_load(0, 21'h41, 1'b1, '1);
		for (int i = 0; i < 5; i++)
			push_byte(8'h41);
		push_op(F_END);

		// zero em acts as one, zero pixel size
		set_font(0, 0, 2);
		push_byte(8'h41);
		push_byte(8'h42);
		push_op(F_END);

		// widest settings, count past the table end; duplicate codes, the first match in slot 0 wins
		set_font(4095, 1023, 511);
		push_load(1, 21'h41, 1'b0, 20'h12345);
		push_load(2, 21'h41, 1'b1, 20'h54321);
		push_byte(8'h41);
		void'(push_utf8('1, 0));
		push_op(F_END);

		// random settings, each with a random run of texts and table updates
		while (random_pushed < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: em = 0;
				1: em = 4095;
				default: em = $urandom_range(1, 4095);
			endcase
			set_font(em, ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(0, 1023),
				($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
					: $urandom_range(0, 256));
			for (int k = 0; k < 12; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					push_load($urandom_range(0, MAX_GLYPHS_DEF - 1), rand_code(),
						($urandom_range(0, 4) != 0), ADV_W'($urandom));
					random_pushed++;
				end
				push_text($urandom_range(0, 8));
			end
		end

		settle();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
